// ===== rtl/csoa_pkg.sv =====
// Shared types and constants for the cyclic shift outline alignment block.
`timescale 1ns / 1ps
package csoa_pkg;

  localparam int SHIFT_W = 6;
  localparam int COST_W  = 19;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_ALIGN = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_PREP  = 5'b01000,
    ST_EMIT  = 5'b10000
  } phase_t;

endpackage

// ===== rtl/csoa_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a tag that rides along.
`timescale 1ns / 1ps
module csoa_isqrt #(
  parameter int RB    = 13,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   in_val,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RB-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RB:0]      rem_in;
    logic [RB-1:0]    root_in;
    logic [2*RB-1:0]  val_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [RB:0]      rem_q;
    logic [RB-1:0]    root_q;
    logic [2*RB-1:0]  val_q;
    logic [TAG_W-1:0] tag_q;
    logic             vld_q;
    logic [RB+2:0]    cur;
    logic [RB+2:0]    trial;
    logic [RB+2:0]    diff;

    if (k == 0) begin : g_src
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = in_val;
      assign tag_in  = in_tag;
      assign vld_in  = in_valid;
    end else begin : g_src
      assign rem_in  = g_stage[k-1].rem_q;
      assign root_in = g_stage[k-1].root_q;
      assign val_in  = g_stage[k-1].val_q;
      assign tag_in  = g_stage[k-1].tag_q;
      assign vld_in  = g_stage[k-1].vld_q;
    end

    assign cur   = {rem_in, val_in[2*RB-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      tag_q <= tag_in;
      val_q <= {val_in[2*RB-3:0], 2'b00};
      if (cur >= trial) begin
        rem_q  <= diff[RB:0];
        root_q <= {root_in[RB-2:0], 1'b1};
      end else begin
        rem_q  <= cur[RB:0];
        root_q <= {root_in[RB-2:0], 1'b0};
      end
    end
  end

  assign out_valid = g_stage[RB-1].vld_q;
  assign out_root  = g_stage[RB-1].root_q;
  assign out_tag   = g_stage[RB-1].tag_q;

endmodule

// ===== rtl/cyclic_shift_outline_align_core.sv =====
// Top level of the cyclic shift outline alignment block.
`timescale 1ns / 1ps
// Load one sample/reference point pair per start transfer while busy is low;
// the pair flagged last, or the pair that fills the store, closes the load.
// The block then scores every cyclic shift of the sample outline against the
// reference: one distance term issues per cycle from the two point memories,
// then, once the last term has been scored, the block sets up the rotation and
// emits the rotated outline. Results come out one per cycle with strobe high
// for exactly one cycle each; the receiver cannot stall them, so sample them on
// strobe. end_of_run marks the final rotated point. busy stays high from the
// closing transfer until the last result is on the ports.
module cyclic_shift_outline_align_core
  import csoa_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] sample_x,
  input  logic signed [COORD_BITS-1:0] sample_y,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic                         last,
  output logic                         strobe,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [SHIFT_W-1:0]           best_shift,
  output logic [COST_W-1:0]            least_cost,
  output logic                         end_of_run
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CB    = COORD_BITS;
  localparam int RB    = CB + 1;      // root bits: dx^2+dy^2 < 2^(2*CB+1)
  localparam int TAG_W = AW + 2;      // shift index, end of shift, final term

  phase_t state;

  // Point memories: {x, y} per entry, read every cycle, data registered.
  logic [2*CB-1:0] smem [0:MAX_POINTS-1];
  logic [2*CB-1:0] rmem [0:MAX_POINTS-1];
  logic [2*CB-1:0] s_rd;
  logic [2*CB-1:0] r_rd;

  logic [AW-1:0] count;     // load address
  logic [AW-1:0] nm1;       // point count minus one
  logic [AW-1:0] d;         // shift under test
  logic [AW-1:0] i;         // reference index / emit counter
  logic [AW-1:0] j;         // sample index, (i + d) mod n

  logic              accept;
  logic              closing;
  logic              issue;
  logic [TAG_W-1:0]  issue_tag;

  // Distance pipeline.
  logic              v1, v2, v3, v4;
  logic [TAG_W-1:0]  t1, t2, t3, t4;
  logic [CB-1:0]     ax, ay;
  logic [2*CB-1:0]   sqx, sqy;
  logic [2*CB:0]     sumsq;
  logic signed [CB:0] dx, dy;

  logic              q_valid;
  logic [RB-1:0]     q_root;
  logic [TAG_W-1:0]  q_tag;

  logic [COST_W-1:0] acc;
  logic [COST_W:0]   acc_sum;
  logic [COST_W-1:0] acc_sat;
  logic [COST_W-1:0] best_cost;
  logic [AW-1:0]     best_d;

  assign busy    = (state != ST_LOAD);
  assign accept  = start && !busy;
  assign closing = last || (count == AW'(MAX_POINTS - 1));
  assign issue   = (state == ST_ALIGN);
  assign issue_tag = {(i == nm1) && (d == nm1), i == nm1, d};

  // Memory writes on load, registered reads at the sample/reference indexes.
  always_ff @(posedge clk) begin
    if (accept) begin
      smem[count] <= {sample_x, sample_y};
      rmem[count] <= {ref_x, ref_y};
    end
    s_rd <= smem[j];
    r_rd <= rmem[i];
  end

  // Sequencer: load, issue all terms, drain, set up rotation, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            count <= count + 1'b1;
            if (closing) begin
              nm1   <= count;
              d     <= '0;
              i     <= '0;
              j     <= '0;
              state <= ST_ALIGN;
            end
          end
        end
        ST_ALIGN: begin
          // Advance the term index; wrap to the next shift at the end of a row.
          if (i == nm1) begin
            i <= '0;
            d <= d + 1'b1;
            j <= d + 1'b1;
            if (d == nm1) state <= ST_DRAIN;
          end else begin
            i <= i + 1'b1;
            j <= (j == nm1) ? '0 : j + 1'b1;
          end
        end
        ST_DRAIN: begin
          // Hold until the final term of the last shift has been scored.
          if (q_valid && q_tag[TAG_W-1]) state <= ST_PREP;
        end
        ST_PREP: begin
          i     <= '0;
          j     <= best_d;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe     <= 1'b1;
          end_of_run <= (i == nm1);
          i <= i + 1'b1;
          j <= (j == nm1) ? '0 : j + 1'b1;
          if (i == nm1) begin
            count <= '0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Distance pipeline control: valid bits reset, payload free running.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign dx = $signed({s_rd[2*CB-1], s_rd[2*CB-1:CB]}) - $signed({r_rd[2*CB-1], r_rd[2*CB-1:CB]});
  assign dy = $signed({s_rd[CB-1], s_rd[CB-1:0]}) - $signed({r_rd[CB-1], r_rd[CB-1:0]});

  always_ff @(posedge clk) begin
    t1    <= issue_tag;
    t2    <= t1;
    ax    <= dx[CB] ? CB'(-dx) : CB'(dx);
    ay    <= dy[CB] ? CB'(-dy) : CB'(dy);
    t3    <= t2;
    sqx   <= ax * ax;
    sqy   <= ay * ay;
    t4    <= t3;
    sumsq <= {1'b0, sqx} + {1'b0, sqy};
  end

  csoa_isqrt #(
    .RB    (RB),
    .TAG_W (TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_val    ({1'b0, sumsq}),
    .in_tag    (t4),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_tag   (q_tag)
  );

  // Saturating cost accumulator; a shift wins only on a strictly lower cost.
  assign acc_sum = {1'b0, acc} + (COST_W + 1)'(q_root);
  assign acc_sat = acc_sum[COST_W] ? COST_MAX : acc_sum[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      best_cost <= COST_MAX;
      best_d    <= '0;
    end else if (accept && closing) begin
      acc       <= '0;
      best_cost <= COST_MAX;
      best_d    <= '0;
    end else if (q_valid) begin
      if (q_tag[TAG_W-2]) begin
        acc <= '0;
        if (acc_sat < best_cost) begin
          best_cost <= acc_sat;
          best_d    <= q_tag[AW-1:0];
        end
      end else begin
        acc <= acc_sat;
      end
    end
  end

  assign out_x      = s_rd[2*CB-1:CB];
  assign out_y      = s_rd[CB-1:0];
  assign best_shift = SHIFT_W'(best_d);
  assign least_cost = best_cost;

endmodule

// ===== dv/csoa_scoreboard.sv =====
// Checker for the cyclic shift outline align block: predicts rotated outlines and compares.
`timescale 1ns / 1ps
module csoa_scoreboard
  import csoa_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [COORD_BITS-1:0] sample_x,
  input  logic signed [COORD_BITS-1:0] sample_y,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic                         last,
  input  logic                         strobe,
  input  logic signed [COORD_BITS-1:0] out_x,
  input  logic signed [COORD_BITS-1:0] out_y,
  input  logic [SHIFT_W-1:0]           best_shift,
  input  logic [COST_W-1:0]            least_cost,
  input  logic                         end_of_run,
  output int                           fail_count,
  output int                           pending,
  output int                           runs_done
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [SHIFT_W-1:0]           shift;
    logic [COST_W-1:0]            cost;
    logic                         eor;
  } aligned_pt_t;

  aligned_pt_t rotated_q[$];
  logic signed [COORD_BITS-1:0] smp_x[MAX_POINTS], smp_y[MAX_POINTS];
  logic signed [COORD_BITS-1:0] rf_x[MAX_POINTS], rf_y[MAX_POINTS];
  int loaded;

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Score every shift, keep the strict minimum, queue the rotated outline.
  task automatic align_outline(int n);
    longint cost, best_c, dx, dy;
    int best_d, j;
    aligned_pt_t p;
    best_c = COST_MAX;
    best_d = 0;
    for (int d = 0; d < n; d++) begin
      cost = 0;
      for (int i = 0; i < n; i++) begin
        j = (i + d) % n;
        dx = longint'(smp_x[j]) - longint'(rf_x[i]);
        dy = longint'(smp_y[j]) - longint'(rf_y[i]);
        cost += floor_sqrt(dx * dx + dy * dy);
        if (cost > COST_MAX) cost = COST_MAX;
      end
      if (cost < best_c) begin
        best_c = cost;
        best_d = d;
      end
    end
    for (int k = 0; k < n; k++) begin
      j = (k + best_d) % n;
      p.x = smp_x[j];
      p.y = smp_y[j];
      p.shift = best_d[SHIFT_W-1:0];
      p.cost = best_c[COST_W-1:0];
      p.eor = (k == n - 1);
      rotated_q = {rotated_q, p};
    end
  endtask

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    aligned_pt_t e;
    int errs;
    errs = 0;
    if (rst) begin
      loaded = 0;
      fail_count <= 0;
      runs_done <= 0;
    end else begin
      if (strobe) begin
        if (rotated_q.size() == 0) begin
          $error("result with nothing expected: x=%0d y=%0d", out_x, out_y);
          errs++;
        end else begin
          e = rotated_q.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %0d got %0d", e.x, out_x);
            errs++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d got %0d", e.y, out_y);
            errs++;
          end
          if (best_shift !== e.shift) begin
            $error("best_shift expected %0d got %0d", e.shift, best_shift);
            errs++;
          end
          if (least_cost !== e.cost) begin
            $error("least_cost expected %0d got %0d", e.cost, least_cost);
            errs++;
          end
          if (end_of_run !== e.eor) begin
            $error("end_of_run expected %0d got %0d", e.eor, end_of_run);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        smp_x[loaded] = sample_x;
        smp_y[loaded] = sample_y;
        rf_x[loaded] = ref_x;
        rf_y[loaded] = ref_y;
        loaded++;
        if (last || loaded == MAX_POINTS) begin
          align_outline(loaded);
          loaded = 0;
          runs_done <= runs_done + 1;
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== dv/tb_cyclic_shift_outline_align_core.sv =====
// Testbench top for the cyclic shift outline align block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_cyclic_shift_outline_align_core
  import csoa_pkg::*;
;

  localparam int MAXP = 64;
  localparam int CW   = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] sample_x = '0, sample_y = '0, ref_x = '0, ref_y = '0;
  logic last = 1'b0;
  logic strobe;
  logic signed [CW-1:0] out_x, out_y;
  logic [SHIFT_W-1:0] best_shift;
  logic [COST_W-1:0] least_cost;
  logic end_of_run;
  int fail_count, pending, runs_done;
  int items_sent = 0;
  // Random idling on the sender; zero during the quiet stretch.
  int idle_pct = 19;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cyclic_shift_outline_align_core #(.MAX_POINTS(MAXP), .COORD_BITS(CW)) dut (
    .clk, .rst, .start, .busy, .sample_x, .sample_y, .ref_x, .ref_y, .last,
    .strobe, .out_x, .out_y, .best_shift, .least_cost, .end_of_run
  );

  csoa_scoreboard #(.MAX_POINTS(MAXP), .COORD_BITS(CW)) checker_i (
    .clk, .rst, .start, .busy, .sample_x, .sample_y, .ref_x, .ref_y, .last,
    .strobe, .out_x, .out_y, .best_shift, .least_cost, .end_of_run,
    .fail_count, .pending, .runs_done
  );

  // Present one point pair and hold it until the transfer happens; start
  // stays high afterwards until the next pair or a drain lowers it.
  task automatic send_pair(logic signed [CW-1:0] sx, sy, rx, ry, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample_x <= sx;
    sample_y <= sy;
    ref_x <= rx;
    ref_y <= ry;
    last <= lst;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(5))
      0: return 12'sh800;
      1: return 12'sh7ff;
      2: return CW'($signed($urandom_range(15)) - 8);
      default: return CW'($urandom);
    endcase
  endfunction

  // Send a well-formed outline of n points with random content.
  task automatic send_outline(int n, bit close_by_fill);
    for (int i = 0; i < n; i++)
      send_pair(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                close_by_fill ? 1'b0 : (i == n - 1));
  endtask

  // Drop start and hold until every expected result has come.
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single point, extremes, ties, exact rotation.
    send_pair(12'sh800, 12'sh7ff, 12'sh7ff, 12'sh800, 1'b1);
    send_pair('0, '0, '0, '0, 1'b0);
    send_pair('0, '0, '0, '0, 1'b1);
    send_pair(12'sd1, 12'sd2, 12'sd3, 12'sd4, 1'b0);
    send_pair(12'sd3, 12'sd4, 12'sd5, 12'sd6, 1'b0);
    send_pair(12'sd5, 12'sd6, 12'sd1, 12'sd2, 1'b1);
    // Largest distances in every term of shift zero.
    for (int i = 0; i < 8; i++)
      send_pair((i % 2) ? 12'sh800 : 12'sh7ff, 12'sh800,
                (i % 2) ? 12'sh7ff : 12'sh800, 12'sh7ff, i == 7);
    for (int i = 0; i < 4; i++)
      send_pair(CW'(-i), CW'(i), CW'(i), CW'(-i), i == 3);
    // Hold off until the whole outline has drained.
    wait_drain();
    // Fill the store without a last flag.
    send_outline(MAXP, 1'b1);
    wait_drain();

    // Random outlines, mostly short; a quiet stretch with no idling.
    while (items_sent < 270) begin
      idle_pct = (items_sent > 150 && items_sent < 200) ? 0 : 19;
      n = ($urandom_range(19) == 0) ? $urandom_range(MAXP, 30) : $urandom_range(12, 1);
      send_outline(n, n == MAXP);
      if ($urandom_range(9) == 0) wait_drain();
    end

    wait_drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d point pairs in %0d outlines of 1 to %0d points.",
             items_sent, runs_done, MAXP);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csoa_pkg.sv
rtl/csoa_isqrt.sv
rtl/cyclic_shift_outline_align_core.sv
dv/csoa_scoreboard.sv
dv/tb_cyclic_shift_outline_align_core.sv
